// ----- rtl/mtf_pkg.sv -----
package mtf_pkg;

    // Operation codes on func
    localparam logic [1:0] FUNC_PUSH   = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_POP    = 2'd2;
    localparam logic [1:0] FUNC_FIND   = 2'd3;

    // Fixed port field widths
    localparam int FUNC_W  = 2;
    localparam int PORT_ID_W  = 6;
    localparam int PORT_CNT_W = 5;

    // Parameter defaults
    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 6;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;    // insert / move to front
        logic remove;  // unlink the matching entry
        logic pop;     // unlink the head
    } ctrl_t;

endpackage

// ----- rtl/move_to_front_focus_list_core.sv -----
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | func, client_id, is_floating, is_minimized
// out     | output    | out_valid / out_ready| found, popped_valid, popped_id, head_valid,
//         |           |                      | head_id, tiled_valid, tiled_id, entry_count,
//         |           |                      | overflow
//
// One item per cycle sustained while out_ready holds. The transfer edge updates the
// cell row; the edge that empties the pending stage loads head/tiled from the updated
// row into the output register. The walk ripples through all DEPTH cells.
// Reset clears the count and the handshake state; cell contents are don't-care.
// A stalled output holds one finished result plus one in the pending stage,
// after which in_ready drops until out_ready frees the output register.
module move_to_front_focus_list_core #(
    parameter int DEPTH   = mtf_pkg::DEPTH_DEF,
    parameter int ID_BITS = mtf_pkg::ID_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mtf_pkg::FUNC_W-1:0]    func,
    input  logic [mtf_pkg::PORT_ID_W-1:0] client_id,
    input  logic                          is_floating,
    input  logic                          is_minimized,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic                          popped_valid,
    output logic [mtf_pkg::PORT_ID_W-1:0] popped_id,
    output logic                          head_valid,
    output logic [mtf_pkg::PORT_ID_W-1:0] head_id,
    output logic                          tiled_valid,
    output logic [mtf_pkg::PORT_ID_W-1:0] tiled_id,
    output logic [mtf_pkg::PORT_CNT_W-1:0] entry_count,
    output logic                          overflow
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PIW = mtf_pkg::PORT_ID_W;
    localparam int PCW = mtf_pkg::PORT_CNT_W;

    // ---------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------
    logic                     xfer_in;
    logic [ID_BITS+PIW-1:0]   key_wide;
    logic [ID_BITS-1:0]       key;
    logic                     hit_any;
    logic                     is_full;
    mtf_pkg::ctrl_t           ctrl;

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;

    // client_id masked / extended to the list's id width
    assign key_wide = {{ID_BITS{1'b0}}, client_id};
    assign key      = key_wide[ID_BITS-1:0];
    assign is_full  = (count_reg == CW'(DEPTH));
    assign xfer_in  = in_valid && in_ready;

    always_comb
    begin
        ctrl = '0;
        if (xfer_in)
        begin
            case (func)
                mtf_pkg::FUNC_PUSH:
                    ctrl.push = !is_minimized && (hit_any || !is_full);
                mtf_pkg::FUNC_REMOVE:
                    ctrl.remove = hit_any;
                mtf_pkg::FUNC_POP:
                    ctrl.pop = (count_reg != '0);
                mtf_pkg::FUNC_FIND:
                    ctrl = '0;
                default:
                    ctrl = '0;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push && !hit_any)
            count_next = count_reg + CW'(1);
        else if (ctrl.remove || ctrl.pop)
            count_next = count_reg - CW'(1);
    end

    // ---------------------------------------------------------------
    // Cell row: slot 0 is the front
    // ---------------------------------------------------------------
    logic [DEPTH:0]               hit_chain;
    logic [DEPTH:0]               tv_chain;
    logic [ID_BITS-1:0]           tid_chain [DEPTH+1];
    logic [ID_BITS-1:0]           cell_id   [DEPTH];
    logic [DEPTH-1:0]             cell_flt;
    logic [DEPTH-1:0]             occ;

    assign hit_chain[0] = 1'b0;
    assign tv_chain[0]  = 1'b0;
    assign tid_chain[0] = '0;
    assign hit_any      = hit_chain[DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ID_BITS-1:0] l_id;
        logic               l_flt;
        logic [ID_BITS-1:0] r_id;
        logic               r_flt;

        assign occ[i] = (count_reg > CW'(i));

        if (i == 0)
        begin : g_front
            assign l_id  = key;
            assign l_flt = is_floating;
        end
        else
        begin : g_mid
            assign l_id  = cell_id[i-1];
            assign l_flt = cell_flt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_back
            assign r_id  = cell_id[i];
            assign r_flt = cell_flt[i];
        end
        else
        begin : g_inner
            assign r_id  = cell_id[i+1];
            assign r_flt = cell_flt[i+1];
        end

        mtf_cell #(
            .ID_BITS(ID_BITS)
        ) u_cell (
            .clk            (clk),
            .ctrl           (ctrl),
            .key            (key),
            .occ            (occ[i]),
            .left_id        (l_id),
            .left_flt       (l_flt),
            .right_id       (r_id),
            .right_flt      (r_flt),
            .hit_in         (hit_chain[i]),
            .hit_out        (hit_chain[i+1]),
            .tiled_in_valid (tv_chain[i]),
            .tiled_in_id    (tid_chain[i]),
            .tiled_out_valid(tv_chain[i+1]),
            .tiled_out_id   (tid_chain[i+1]),
            .id_q           (cell_id[i]),
            .flt_q          (cell_flt[i])
        );
    end

    // ---------------------------------------------------------------
    // Pending stage: per-op flags captured at transfer
    // ---------------------------------------------------------------
    logic               pend_valid_reg;
    logic               pend_found_reg;
    logic               pend_popped_reg;
    logic [ID_BITS-1:0] pend_popped_id_reg;
    logic               pend_overflow_reg;
    logic               pend_move;

    assign pend_move = pend_valid_reg && (!out_valid || out_ready);
    assign in_ready  = !pend_valid_reg || pend_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (xfer_in)
                pend_valid_reg <= 1'b1;
            else if (pend_move)
                pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer_in)
        begin
            pend_found_reg     <= hit_any;
            pend_popped_reg    <= ctrl.pop;
            pend_popped_id_reg <= ctrl.pop ? cell_id[0] : '0;
            pend_overflow_reg  <= (func == mtf_pkg::FUNC_PUSH) && !is_minimized
                                  && !hit_any && is_full;
        end
    end

    // ---------------------------------------------------------------
    // Output register: head and tiled read from the updated row
    // ---------------------------------------------------------------
    logic                   out_valid_reg;
    logic                   found_reg;
    logic                   popped_valid_reg;
    logic [PIW-1:0]         popped_id_reg;
    logic                   head_valid_reg;
    logic [PIW-1:0]         head_id_reg;
    logic                   tiled_valid_reg;
    logic [PIW-1:0]         tiled_id_reg;
    logic [PCW-1:0]         entry_count_reg;
    logic                   overflow_reg;

    logic                   head_nz;
    logic [ID_BITS+PIW-1:0] head_wide;
    logic [ID_BITS+PIW-1:0] tiled_wide;
    logic [ID_BITS+PIW-1:0] popped_wide;
    logic [CW+PCW-1:0]      count_wide;

    assign head_nz     = (count_reg != '0);
    assign head_wide   = {{PIW{1'b0}}, (head_nz ? cell_id[0] : {ID_BITS{1'b0}})};
    assign tiled_wide  = {{PIW{1'b0}},
                          (tv_chain[DEPTH] ? tid_chain[DEPTH] : {ID_BITS{1'b0}})};
    assign popped_wide = {{PIW{1'b0}}, pend_popped_id_reg};
    assign count_wide  = {{PCW{1'b0}}, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pend_move)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pend_move)
        begin
            found_reg        <= pend_found_reg;
            popped_valid_reg <= pend_popped_reg;
            popped_id_reg    <= popped_wide[PIW-1:0];
            head_valid_reg   <= head_nz;
            head_id_reg      <= head_wide[PIW-1:0];
            tiled_valid_reg  <= tv_chain[DEPTH];
            tiled_id_reg     <= tiled_wide[PIW-1:0];
            entry_count_reg  <= count_wide[PCW-1:0];
            overflow_reg     <= pend_overflow_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign popped_valid = popped_valid_reg;
    assign popped_id    = popped_id_reg;
    assign head_valid   = head_valid_reg;
    assign head_id      = head_id_reg;
    assign tiled_valid  = tiled_valid_reg;
    assign tiled_id     = tiled_id_reg;
    assign entry_count  = entry_count_reg;
    assign overflow     = overflow_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_xfer_pends: assert property (@(posedge clk) disable iff (!rst_n)
        xfer_in |=> pend_valid_reg)
        else $error("transfer did not reach pending stage");

    a_ovf_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(overflow && found))
        else $error("overflow reported for a present id");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !head_valid) |-> (entry_count == '0 && !tiled_valid))
        else $error("empty list with entries reported");

endmodule

// ----- rtl/mtf_cell.sv -----
module mtf_cell #(
    parameter int ID_BITS = mtf_pkg::ID_BITS_DEF
) (
    input  logic               clk,
    input  mtf_pkg::ctrl_t     ctrl,
    input  logic [ID_BITS-1:0] key,
    input  logic               occ,
    input  logic [ID_BITS-1:0] left_id,
    input  logic               left_flt,
    input  logic [ID_BITS-1:0] right_id,
    input  logic               right_flt,
    input  logic               hit_in,
    output logic               hit_out,
    input  logic               tiled_in_valid,
    input  logic [ID_BITS-1:0] tiled_in_id,
    output logic               tiled_out_valid,
    output logic [ID_BITS-1:0] tiled_out_id,
    output logic [ID_BITS-1:0] id_q,
    output logic               flt_q
);

    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;
    logic               flt_reg;
    logic               flt_next;
    logic               match;
    logic               shift_in_left;
    logic               shift_in_right;

    assign match   = occ && (id_reg == key);
    assign hit_out = hit_in || match;

    // push: every entry ahead of the old slot (all, if none) moves back one over it
    // remove: everything from the hit onward moves forward one; pop: everything does
    assign shift_in_left  = ctrl.push && !hit_in;
    assign shift_in_right = ctrl.pop || (ctrl.remove && (hit_in || match));

    always_comb
    begin
        id_next  = id_reg;
        flt_next = flt_reg;
        if (shift_in_left)
        begin
            id_next  = left_id;
            flt_next = left_flt;
        end
        else if (shift_in_right)
        begin
            id_next  = right_id;
            flt_next = right_flt;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        flt_reg <= flt_next;
    end

    // first non-floating entry, front to back
    assign tiled_out_valid = tiled_in_valid || (occ && !flt_reg);
    assign tiled_out_id    = tiled_in_valid ? tiled_in_id : id_reg;

    assign id_q  = id_reg;
    assign flt_q = flt_reg;

endmodule
